### hw/rtl/eclt_pkg.sv
// Package for the ear clipping triangulator: sequencer states, area unit
// phases and operand selection codes. Depends on nothing.
`default_nettype none

package eclt_pkg;

  // Main sequencer states.
  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_CHECK, S_LRD, S_LWT, S_VP, S_VT, S_VN, S_VW,
    S_T2, S_T2W, S_JL, S_JLW, S_JCHK, S_JW, S_SUB, S_SUBW, S_CMP,
    S_EMIT, S_MISS, S_ERR
  } state_e;

  // Phases of the shared turn unit.
  typedef enum logic [1:0] {
    PH_IDLE, PH_MUL_A, PH_MUL_B, PH_SUB
  } area_ph_e;

  // Which three corners feed the turn unit.
  typedef enum logic [1:0] {
    OP_JTN, OP_PJN, OP_PTJ, OP_PTN
  } area_op_e;

  // Reset value of the inside tolerance.
  localparam logic [15:0] TOL_RESET = 16'd512;

endpackage

`default_nettype wire

### hw/rtl/eclt_if.sv
// Channel interfaces of the ear clipping triangulator: vertex input,
// triangle output and tolerance write. Depends on nothing.
`default_nettype none

interface eclt_vtx_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface eclt_tri_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] tri_ax;
  logic signed [COORD_BITS-1:0] tri_ay;
  logic signed [COORD_BITS-1:0] tri_bx;
  logic signed [COORD_BITS-1:0] tri_by;
  logic signed [COORD_BITS-1:0] tri_cx;
  logic signed [COORD_BITS-1:0] tri_cy;
  logic                         last_triangle;
  logic                         error_flag;
  modport source (output valid, tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy,
                  last_triangle, error_flag, input ready);
  modport sink   (input valid, tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy,
                  last_triangle, error_flag, output ready);
endinterface

interface eclt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] area_tolerance;
  modport source (output valid, area_tolerance, input ready);
  modport sink   (input valid, area_tolerance, output ready);
endinterface

`default_nettype wire

### hw/rtl/eclt_vertex_mem.sv
// Vertex coordinate store: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module eclt_vertex_mem #(
  parameter int DEPTH      = 64,
  parameter int COORD_BITS = 16,
  parameter int IW         = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [IW-1:0]         waddr_i,
  input  wire logic [COORD_BITS-1:0] wx_i,
  input  wire logic [COORD_BITS-1:0] wy_i,
  input  wire logic [IW-1:0]         raddr_i,
  output logic      [COORD_BITS-1:0] rx_o,
  output logic      [COORD_BITS-1:0] ry_o
);

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rd_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wx_i, wy_i};
    end
    rd_q <= mem[raddr_i];
  end

  assign rx_o = rd_q[2*COORD_BITS-1:COORD_BITS];
  assign ry_o = rd_q[COORD_BITS-1:0];

endmodule

`default_nettype wire

### hw/rtl/eclt_link_mem.sv
// Ring link store: next and prev fields with their own write ports and a
// shared registered read address. Depends on nothing.
`default_nettype none

module eclt_link_mem #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          next_we_i,
  input  wire logic [IW-1:0] next_waddr_i,
  input  wire logic [IW-1:0] next_wdata_i,
  input  wire logic          prev_we_i,
  input  wire logic [IW-1:0] prev_waddr_i,
  input  wire logic [IW-1:0] prev_wdata_i,
  input  wire logic [IW-1:0] raddr_i,
  output logic      [IW-1:0] next_o,
  output logic      [IW-1:0] prev_o
);

  logic [IW-1:0] next_mem [DEPTH];
  logic [IW-1:0] prev_mem [DEPTH];

  // Field writes and registered read.
  always_ff @(posedge clk_i) begin
    if (next_we_i) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    if (prev_we_i) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
    next_o <= next_mem[raddr_i];
    prev_o <= prev_mem[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/eclt_area_unit.sv
// Shared turn unit: (b-a) x (c-b) with one multiplier.
// Depends on eclt_pkg.
`default_nettype none

module eclt_area_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [COORD_BITS-1:0] ax_i,
  input  wire logic signed [COORD_BITS-1:0] ay_i,
  input  wire logic signed [COORD_BITS-1:0] bx_i,
  input  wire logic signed [COORD_BITS-1:0] by_i,
  input  wire logic signed [COORD_BITS-1:0] cx_i,
  input  wire logic signed [COORD_BITS-1:0] cy_i,
  output logic                              done_o,
  output logic signed [2*COORD_BITS+2:0]    turn_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int TW = PW + 1;

  eclt_pkg::area_ph_e ph_q, ph_d;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod_q, acc_q, mul;
  logic signed [TW-1:0] turn_q;
  logic                 done_q;

  // Phase sequencing.
  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      eclt_pkg::PH_IDLE:  if (start_i) ph_d = eclt_pkg::PH_MUL_A;
      eclt_pkg::PH_MUL_A: ph_d = eclt_pkg::PH_MUL_B;
      eclt_pkg::PH_MUL_B: ph_d = eclt_pkg::PH_SUB;
      eclt_pkg::PH_SUB:   ph_d = eclt_pkg::PH_IDLE;
      default:            ph_d = eclt_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= eclt_pkg::PH_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == eclt_pkg::PH_SUB);
    end
  end

  // The single multiplier takes the first cross term, then the second.
  assign op_a = (ph_q == eclt_pkg::PH_MUL_A) ? d1x_q : d1y_q;
  assign op_b = (ph_q == eclt_pkg::PH_MUL_A) ? d2y_q : d2x_q;
  assign mul  = PW'(op_a) * PW'(op_b);

  // Edge vectors, products and the final difference.
  always_ff @(posedge clk_i) begin
    if (ph_q == eclt_pkg::PH_IDLE && start_i) begin
      d1x_q <= DW'(bx_i) - DW'(ax_i);
      d1y_q <= DW'(by_i) - DW'(ay_i);
      d2x_q <= DW'(cx_i) - DW'(bx_i);
      d2y_q <= DW'(cy_i) - DW'(by_i);
    end
    if (ph_q == eclt_pkg::PH_MUL_A || ph_q == eclt_pkg::PH_MUL_B) begin
      prod_q <= mul;
    end
    if (ph_q == eclt_pkg::PH_MUL_B) begin
      acc_q <= prod_q;
    end
    if (ph_q == eclt_pkg::PH_SUB) begin
      turn_q <= TW'(acc_q) - TW'(prod_q);
    end
  end

  assign done_o = done_q;
  assign turn_o = turn_q;

endmodule

`default_nettype wire

### hw/rtl/ear_clipping_triangulator.sv
// Ear clipping triangulator. Vertices of a simple polygon arrive on vtx_i,
// one transfer each, the last one flagged by last_vertex. They are stored at
// one per cycle. After the last vertex the ring links are built and ears
// are clipped; each clipped ear leaves as one transfer
// on tri_o, the final triangle with last_triangle set. Fewer than three
// vertices, or a full round of the ring without an ear, ends the polygon
// with an error result (error_flag and last_triangle set, coordinates zero).
// Each candidate tip reads its links and coordinates and runs the corner
// test, then finds the first other vertex, and then runs the inside test
// for each other remaining vertex in turn until one is found inside, paced
// by the single read port of the vertex memory and the shared turn unit.
// vtx_i is not ready while a polygon is being clipped. A result sits in an
// output register; when tri_o stalls the clipping waits at the next result.
// cfg_i is always ready and sets the inside tolerance (512 after reset).
// Reset returns the block to waiting for the first vertex of a polygon.
// Depends on eclt_pkg, eclt_if, eclt_vertex_mem, eclt_link_mem, eclt_area_unit.
`default_nettype none

module ear_clipping_triangulator #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eclt_vtx_if.sink   vtx_i,
  eclt_tri_if.source tri_o,
  eclt_cfg_if.sink   cfg_i
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CB = COORD_BITS;
  localparam int TW = 2 * COORD_BITS + 3;
  localparam int SW = TW + 3;

  eclt_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   tol_q;

  logic [CW-1:0] n_q, n_d, remaining_q, remaining_d, misses_q, misses_d, cnt_q, cnt_d;
  logic [IW-1:0] i_q, i_d, tip_q, tip_d, head_q, head_d;
  logic [IW-1:0] pi_q, pi_d, ti_q, ti_d, ni_q, ni_d, j_q, j_d, jn_q, jn_d;
  logic          final_q, final_d;
  eclt_pkg::area_op_e sel_q, sel_d;
  logic signed [CB-1:0] px_q, py_q, tx_q, ty_q, nx_q, ny_q, jx_q, jy_q;
  logic          cap_p, cap_t, cap_n, cap_j;
  logic [SW-1:0] sum_q, sum_d;
  logic signed [TW-1:0] t2_q, t2_d;

  logic signed [CB-1:0] o_ax_q, o_ay_q, o_bx_q, o_by_q, o_cx_q, o_cy_q;
  logic o_last_q, o_err_q, load_tri, load_err;

  logic          vm_we;
  logic [IW-1:0] vm_raddr, lm_raddr;
  logic [CB-1:0] vm_rx, vm_ry;
  logic          nx_we, pv_we;
  logic [IW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata, lm_next, lm_prev;
  logic [CW-1:0] i_ext, i_inc, n_fin;

  logic          au_start, au_done;
  logic signed [CB-1:0] au_ax, au_ay, au_bx, au_by, au_cx, au_cy;
  logic signed [TW-1:0] au_turn;
  logic [TW-1:0] turn_mag;
  logic signed [SW-1:0] diff;
  logic [SW-1:0] diff_mag;
  logic          pt_in, vtx_xfer, ofree, store_ok;

  assign vtx_i.ready = (state_q == eclt_pkg::S_LOAD);
  assign cfg_i.ready = 1'b1;
  assign vtx_xfer    = vtx_i.valid && vtx_i.ready;
  assign ofree       = !out_valid_q || tri_o.ready;
  assign store_ok    = (count_q < CW'(MAX_VERTICES));
  assign n_fin       = count_q + CW'(store_ok);
  assign i_ext       = CW'(i_q);
  assign i_inc       = i_ext + CW'(1);

  // Memories.
  assign vm_we = vtx_xfer && store_ok;

  eclt_vertex_mem #(.DEPTH(MAX_VERTICES), .COORD_BITS(COORD_BITS), .IW(IW)) u_vmem (
    .clk_i   (clk_i),
    .we_i    (vm_we),
    .waddr_i (count_q[IW-1:0]),
    .wx_i    (vtx_i.vertex_x),
    .wy_i    (vtx_i.vertex_y),
    .raddr_i (vm_raddr),
    .rx_o    (vm_rx),
    .ry_o    (vm_ry)
  );

  eclt_link_mem #(.DEPTH(MAX_VERTICES), .IW(IW)) u_lmem (
    .clk_i        (clk_i),
    .next_we_i    (nx_we),
    .next_waddr_i (nx_waddr),
    .next_wdata_i (nx_wdata),
    .prev_we_i    (pv_we),
    .prev_waddr_i (pv_waddr),
    .prev_wdata_i (pv_wdata),
    .raddr_i      (lm_raddr),
    .next_o       (lm_next),
    .prev_o       (lm_prev)
  );

  // Corner selection for the turn unit.
  always_comb begin
    au_ax = px_q; au_ay = py_q; au_bx = tx_q; au_by = ty_q; au_cx = nx_q; au_cy = ny_q;
    case (sel_q)
      eclt_pkg::OP_JTN: begin au_ax = jx_q; au_ay = jy_q; end
      eclt_pkg::OP_PJN: begin au_bx = jx_q; au_by = jy_q; end
      eclt_pkg::OP_PTJ: begin au_cx = jx_q; au_cy = jy_q; end
      eclt_pkg::OP_PTN: ;
      default: ;
    endcase
  end

  eclt_area_unit #(.COORD_BITS(COORD_BITS)) u_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (au_start),
    .ax_i    (au_ax),
    .ay_i    (au_ay),
    .bx_i    (au_bx),
    .by_i    (au_by),
    .cx_i    (au_cx),
    .cy_i    (au_cy),
    .done_o  (au_done),
    .turn_o  (au_turn)
  );

  // Sub-area magnitudes and the inside test.
  assign turn_mag = au_turn[TW-1] ? TW'(-au_turn) : TW'(au_turn);
  assign diff     = $signed(sum_q) - SW'(t2_q);
  assign diff_mag = diff[SW-1] ? SW'(-diff) : SW'(diff);
  assign pt_in    = diff_mag < SW'(tol_q);

  // Sequencer: next state, memory addresses and register updates.
  always_comb begin
    state_d = state_q; count_d = count_q; out_valid_d = out_valid_q;
    n_d = n_q; remaining_d = remaining_q; misses_d = misses_q; cnt_d = cnt_q;
    i_d = i_q; tip_d = tip_q; head_d = head_q; pi_d = pi_q; ti_d = ti_q; ni_d = ni_q;
    j_d = j_q; jn_d = jn_q; final_d = final_q; sel_d = sel_q; sum_d = sum_q; t2_d = t2_q;
    vm_raddr = ti_q; lm_raddr = ti_q;
    nx_we = 1'b0; nx_waddr = i_q; nx_wdata = i_q;
    pv_we = 1'b0; pv_waddr = i_q; pv_wdata = i_q;
    cap_p = 1'b0; cap_t = 1'b0; cap_n = 1'b0; cap_j = 1'b0;
    au_start = 1'b0; load_tri = 1'b0; load_err = 1'b0;
    if (out_valid_q && tri_o.ready) out_valid_d = 1'b0;
    case (state_q)
      eclt_pkg::S_LOAD: begin
        if (vtx_xfer) begin
          count_d = n_fin;
          if (vtx_i.last_vertex) begin
            count_d = '0;
            n_d     = n_fin;
            i_d     = '0;
            state_d = (n_fin < CW'(3)) ? eclt_pkg::S_ERR : eclt_pkg::S_INIT;
          end
        end
      end
      eclt_pkg::S_INIT: begin
        nx_we    = 1'b1;
        nx_wdata = (i_inc == n_q) ? '0 : IW'(i_inc);
        pv_we    = 1'b1;
        pv_wdata = (i_q == '0) ? IW'(n_q - CW'(1)) : IW'(i_ext - CW'(1));
        i_d      = IW'(i_inc);
        if (i_inc == n_q) begin
          tip_d = '0; head_d = '0; remaining_d = n_q; misses_d = '0;
          state_d = eclt_pkg::S_CHECK;
        end
      end
      eclt_pkg::S_CHECK: begin
        if (remaining_q <= CW'(3)) begin
          ti_d = head_q; final_d = 1'b1; state_d = eclt_pkg::S_LRD;
        end else if (misses_q >= remaining_q) begin
          state_d = eclt_pkg::S_ERR;
        end else begin
          ti_d = tip_q; final_d = 1'b0; state_d = eclt_pkg::S_LRD;
        end
      end
      eclt_pkg::S_LRD: begin
        lm_raddr = ti_q; state_d = eclt_pkg::S_LWT;
      end
      eclt_pkg::S_LWT: begin
        pi_d = lm_prev; ni_d = lm_next; state_d = eclt_pkg::S_VP;
      end
      eclt_pkg::S_VP: begin
        vm_raddr = pi_q; state_d = eclt_pkg::S_VT;
      end
      eclt_pkg::S_VT: begin
        vm_raddr = ti_q; cap_p = 1'b1; state_d = eclt_pkg::S_VN;
      end
      eclt_pkg::S_VN: begin
        vm_raddr = ni_q; cap_t = 1'b1; state_d = eclt_pkg::S_VW;
      end
      eclt_pkg::S_VW: begin
        cap_n = 1'b1; sel_d = eclt_pkg::OP_PTN;
        state_d = final_q ? eclt_pkg::S_EMIT : eclt_pkg::S_T2;
      end
      eclt_pkg::S_T2: begin
        au_start = 1'b1; state_d = eclt_pkg::S_T2W;
      end
      eclt_pkg::S_T2W: begin
        if (au_done) begin
          t2_d    = au_turn;
          state_d = au_turn[TW-1] ? eclt_pkg::S_MISS : eclt_pkg::S_JL;
        end
      end
      eclt_pkg::S_JL: begin
        lm_raddr = ni_q; state_d = eclt_pkg::S_JLW;
      end
      eclt_pkg::S_JLW: begin
        j_d = lm_next; cnt_d = '0; state_d = eclt_pkg::S_JCHK;
      end
      eclt_pkg::S_JCHK: begin
        vm_raddr = j_q; lm_raddr = j_q;
        if (((CW + 1)'(cnt_q) + (CW + 1)'(3) < (CW + 1)'(remaining_q)) && (j_q != pi_q)) begin
          state_d = eclt_pkg::S_JW;
        end else begin
          state_d = eclt_pkg::S_EMIT;
        end
      end
      eclt_pkg::S_JW: begin
        cap_j = 1'b1; jn_d = lm_next; sel_d = eclt_pkg::OP_JTN; sum_d = '0;
        state_d = eclt_pkg::S_SUB;
      end
      eclt_pkg::S_SUB: begin
        au_start = 1'b1; state_d = eclt_pkg::S_SUBW;
      end
      eclt_pkg::S_SUBW: begin
        if (au_done) begin
          sum_d = sum_q + SW'(turn_mag);
          if (sel_q == eclt_pkg::OP_PTJ) begin
            state_d = eclt_pkg::S_CMP;
          end else begin
            sel_d   = (sel_q == eclt_pkg::OP_JTN) ? eclt_pkg::OP_PJN : eclt_pkg::OP_PTJ;
            state_d = eclt_pkg::S_SUB;
          end
        end
      end
      eclt_pkg::S_CMP: begin
        if (pt_in) begin
          state_d = eclt_pkg::S_MISS;
        end else begin
          j_d = jn_q; cnt_d = cnt_q + CW'(1); state_d = eclt_pkg::S_JCHK;
        end
      end
      eclt_pkg::S_EMIT: begin
        if (ofree) begin
          load_tri    = 1'b1;
          out_valid_d = 1'b1;
          if (final_q) begin
            state_d = eclt_pkg::S_LOAD;
          end else begin
            nx_we = 1'b1; nx_waddr = pi_q; nx_wdata = ni_q;
            pv_we = 1'b1; pv_waddr = ni_q; pv_wdata = pi_q;
            if (ti_q == head_q) head_d = ni_q;
            remaining_d = remaining_q - CW'(1);
            misses_d    = '0;
            tip_d       = ni_q;
            state_d     = eclt_pkg::S_CHECK;
          end
        end
      end
      eclt_pkg::S_MISS: begin
        misses_d = misses_q + CW'(1); tip_d = ni_q; state_d = eclt_pkg::S_CHECK;
      end
      eclt_pkg::S_ERR: begin
        if (ofree) begin
          load_err = 1'b1; out_valid_d = 1'b1; state_d = eclt_pkg::S_LOAD;
        end
      end
      default: state_d = eclt_pkg::S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eclt_pkg::S_LOAD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      tol_q       <= eclt_pkg::TOL_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) tol_q <= cfg_i.area_tolerance;
    end
  end

  // Working registers of the clipping walk.
  always_ff @(posedge clk_i) begin
    n_q <= n_d; remaining_q <= remaining_d; misses_q <= misses_d; cnt_q <= cnt_d;
    i_q <= i_d; tip_q <= tip_d; head_q <= head_d; pi_q <= pi_d; ti_q <= ti_d;
    ni_q <= ni_d; j_q <= j_d; jn_q <= jn_d; final_q <= final_d; sel_q <= sel_d;
    sum_q <= sum_d; t2_q <= t2_d;
    if (cap_p) begin px_q <= vm_rx; py_q <= vm_ry; end
    if (cap_t) begin tx_q <= vm_rx; ty_q <= vm_ry; end
    if (cap_n) begin nx_q <= vm_rx; ny_q <= vm_ry; end
    if (cap_j) begin jx_q <= vm_rx; jy_q <= vm_ry; end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_tri) begin
      o_ax_q <= px_q; o_ay_q <= py_q; o_bx_q <= tx_q; o_by_q <= ty_q;
      o_cx_q <= nx_q; o_cy_q <= ny_q; o_last_q <= final_q; o_err_q <= 1'b0;
    end else if (load_err) begin
      o_ax_q <= '0; o_ay_q <= '0; o_bx_q <= '0; o_by_q <= '0;
      o_cx_q <= '0; o_cy_q <= '0; o_last_q <= 1'b1; o_err_q <= 1'b1;
    end
  end

  assign tri_o.valid         = out_valid_q;
  assign tri_o.tri_ax        = o_ax_q;
  assign tri_o.tri_ay        = o_ay_q;
  assign tri_o.tri_bx        = o_bx_q;
  assign tri_o.tri_by        = o_by_q;
  assign tri_o.tri_cx        = o_cx_q;
  assign tri_o.tri_cy        = o_cy_q;
  assign tri_o.last_triangle = o_last_q;
  assign tri_o.error_flag    = o_err_q;

  // An error result always closes the polygon with zero coordinates (ax, bx, cx and cy are checked).
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_o.valid && tri_o.error_flag |-> tri_o.last_triangle && tri_o.tri_ax == '0 &&
      tri_o.tri_bx == '0 && tri_o.tri_cx == '0 && tri_o.tri_cy == '0)
    else $error("error result with nonzero fields");

  // While clipping, the ring never drops below three and misses stay bounded.
  a_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eclt_pkg::S_LRD || state_q == eclt_pkg::S_JCHK ||
     state_q == eclt_pkg::S_EMIT) |-> remaining_q >= CW'(3) && misses_q <= remaining_q)
    else $error("ring count out of range");

  // A clipped ear shrinks the ring by exactly one.
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == eclt_pkg::S_EMIT && ofree && !final_q |=>
      state_q == eclt_pkg::S_CHECK && remaining_q == $past(remaining_q) - CW'(1))
    else $error("clip did not shrink ring");

  // The turn unit is never started while no clipping is in progress.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    au_start |-> !vtx_i.ready)
    else $error("turn unit started while loading");

endmodule

`default_nettype wire
